// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked property with an active-low reset.
`define CGF_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// A stalled beat keeps its valid and its payload.
`define CGF_ASSERT_HOLD(lbl, clk, rst_n, vld, stl, sig) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    (vld && stl) |=> (vld && $stable(sig))) else $error("stalled beat changed");

`endif

// ===== sv/cgf_pkg.sv =====
`default_nettype none
package cgf_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 36;

  localparam logic [CfgIdxW-1:0] CfgFrameWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgFrameHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgKernel      = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgDivisor     = 2'd3;

  localparam logic KindPixel = 1'b0;
  localparam logic KindFlush = 1'b1;

  localparam logic [10:0] FrameWidthRst  = 11'd640;
  localparam logic [11:0] FrameHeightRst = 12'd480;
  localparam logic [35:0] KernelRst      = 36'h111111111;
  localparam logic [6:0]  DivisorRst     = 7'd9;

  typedef struct packed {
    logic       kind;
    logic [7:0] pixel_in;
  } in_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic       end_of_row;
    logic       end_of_frame;
  } out_t;

  typedef logic [8:0][7:0] win_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_CALC  = 5'b00100,
    S_EMIT1 = 5'b01000,
    S_EMIT2 = 5'b10000
  } state_e;

  typedef enum logic [2:0] {
    A_IDLE = 3'b001,
    A_MAC  = 3'b010,
    A_DIV  = 3'b100
  } arith_state_e;

endpackage
`default_nettype wire

// ===== sv/cgf_ram.sv =====
`default_nettype none
module cgf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic                     we_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

// ===== sv/cgf_arith.sv =====
`default_nettype none
module cgf_arith (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire cgf_pkg::win_t win_i,
  input  wire logic [35:0]   weights_i,
  input  wire logic [6:0]    divisor_i,
  output logic               done_o,
  output logic [7:0]         result_o
);
  import cgf_pkg::*;

  arith_state_e     state_q;
  win_t             win_q;
  logic [3:0]       tap_q;
  logic signed [15:0] acc_q;
  logic [14:0]      dvd_q;
  logic [6:0]       rem_q;
  logic [6:0]       div_eff;
  logic signed [3:0]  coef;
  logic signed [12:0] prod;
  logic signed [15:0] acc_d;
  logic [7:0]       rem_s;
  logic             ge;

  assign div_eff = (divisor_i == 7'd0) ? 7'd1 : divisor_i;
  assign coef    = weights_i[tap_q*4 +: 4];
  assign prod    = coef * $signed({1'b0, win_q[tap_q]});
  assign acc_d   = acc_q + 16'(prod);
  assign rem_s   = {rem_q, dvd_q[14]};
  assign ge      = rem_s >= {1'b0, div_eff};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= A_IDLE;
      win_q    <= '0;
      tap_q    <= '0;
      acc_q    <= '0;
      dvd_q    <= '0;
      rem_q    <= '0;
      done_o   <= 1'b0;
      result_o <= '0;
    end else begin
      done_o <= (state_q == A_DIV) && (tap_q == 4'd14);
      unique case (state_q)
        A_IDLE: begin
          if (start_i) begin
            win_q   <= win_i;
            tap_q   <= '0;
            acc_q   <= '0;
            state_q <= A_MAC;
          end
        end
        A_MAC: begin
          if (tap_q == 4'd8) begin
            dvd_q   <= acc_d[15] ? 15'(-acc_d) : acc_d[14:0];
            rem_q   <= '0;
            tap_q   <= '0;
            state_q <= A_DIV;
          end else begin
            acc_q <= acc_d;
            tap_q <= tap_q + 4'd1;
          end
        end
        A_DIV: begin
          // Restoring division, one quotient bit per cycle shifted into dvd_q.
          rem_q <= ge ? 7'(rem_s - {1'b0, div_eff}) : rem_s[6:0];
          dvd_q <= {dvd_q[13:0], ge};
          tap_q <= tap_q + 4'd1;
          if (tap_q == 4'd14) begin
            result_o <= {dvd_q[6:0], ge};
            state_q  <= A_IDLE;
          end
        end
        default: state_q <= A_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== sv/conv3x3_gray_filter.sv =====
// 3x3 convolution over an 8-bit grayscale raster stream.
// Input channel: in_valid_i / in_stall_o with in_data_i (kind, pixel_in).
// Pixel beats in raster order; flush beats emit the pending last row.
// Output channel: out_valid_o / out_stall_i with out_data_o.
// Configuration: cfg_valid_i / cfg_ready_o, index and data; write only while idle.
// Output pixels lag one row and one pixel behind the input.
// A beat the block ignores is only accepted; a pixel with no result is also
// read; a border or flush pixel is read and loaded to the output; an interior
// pixel passes nine taps of multiply-accumulate and fifteen quotient bits of
// bit-serial division in the arithmetic unit, plus accept, read, hand-back and
// output load. A last-column beat after the first row also emits a second result.
// Line stores are single-port RAMs read at accept and written the next cycle.
// Results leave through one output register; when the receiver stalls, the
// block holds the beat and waits before loading a further result.
// Reset restores the register defaults and clears counters and the window;
// line store contents are undefined until written by the first rows.
`default_nettype none
module conv3x3_gray_filter #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire cgf_pkg::in_t                       in_data_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output cgf_pkg::out_t                           out_data_o,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [cgf_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  wire logic [cgf_pkg::CfgDataW-1:0]       cfg_data_i
);
  import cgf_pkg::*;

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned WW = ((CW > 11) ? CW : 11) + 1;

  logic [10:0] fw_q;
  logic [11:0] fh_q;
  logic [35:0] kern_q;
  logic [6:0]  div_q;

  state_e      state_q;
  in_t         item_q;
  logic [AW-1:0] col_q, flush_q, addr_q, rd_addr, ram_addr;
  logic [11:0] row_q;
  win_t        win_q, win_n;
  logic        has2_q;
  logic [7:0]  b_q;
  out_t        res_q;
  out_t        out_q;
  logic        ov_q;

  logic [WW-1:0] fw_ext, eff_w, wm1, col_ext, flush_ext;
  logic [11:0] eff_h;
  logic [12:0] row_inc;
  logic        pending, last_c, last_f, accept, do_work, slot_free, emit;
  logic        has1, has2, border, we, arith_start, arith_done;
  logic [7:0]  older_rd, newer_rd, arith_res;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = state_q != S_IDLE;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;
  assign slot_free   = !ov_q || !out_stall_i;
  assign emit        = ((state_q == S_EMIT1) || (state_q == S_EMIT2)) && slot_free;

  assign fw_ext = WW'(fw_q);
  always_comb begin
    eff_w = fw_ext;
    if (fw_ext < WW'(3)) eff_w = WW'(3);
    if (fw_ext > WW'(MAX_WIDTH)) eff_w = WW'(MAX_WIDTH);
  end
  assign wm1       = eff_w - WW'(1);
  assign eff_h     = (fh_q < 12'd3) ? 12'd3 : fh_q;
  assign pending   = row_q >= eff_h;
  assign col_ext   = WW'(col_q);
  assign flush_ext = WW'(flush_q);
  assign last_c    = col_ext >= wm1;
  assign last_f    = flush_ext >= wm1;
  assign row_inc   = {1'b0, row_q} + 13'd1;

  assign do_work = (in_data_i.kind == KindFlush) ? pending : !pending;
  assign rd_addr = (in_data_i.kind == KindFlush) ? flush_q : col_q;
  assign ram_addr = (state_q == S_READ) ? addr_q : rd_addr;
  assign we = (state_q == S_READ) && (item_q.kind == KindPixel);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_n[i*3]     = win_q[i*3+1];
      win_n[i*3 + 1] = win_q[i*3+2];
    end
    win_n[2] = older_rd;
    win_n[5] = newer_rd;
    win_n[8] = item_q.pixel_in;
  end

  // The output pixel sits at row r-1, column c-1 of the current input.
  assign has1   = (row_q != 12'd0) && (col_q != '0);
  assign has2   = last_c && (row_q != 12'd0);
  assign border = (row_q == 12'd1) || (row_q >= eff_h) ||
                  (col_q == AW'(1)) || (col_ext >= eff_w);
  assign arith_start = (state_q == S_READ) && (item_q.kind == KindPixel) && has1 && !border;

  cgf_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_older (
    .clk_i   (clk_i),
    .addr_i  (ram_addr),
    .we_i    (we),
    .wdata_i (newer_rd),
    .rdata_o (older_rd)
  );

  cgf_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_newer (
    .clk_i   (clk_i),
    .addr_i  (ram_addr),
    .we_i    (we),
    .wdata_i (item_q.pixel_in),
    .rdata_o (newer_rd)
  );

  cgf_arith u_arith (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (arith_start),
    .win_i     (win_n),
    .weights_i (kern_q),
    .divisor_i (div_q),
    .done_o    (arith_done),
    .result_o  (arith_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q   <= FrameWidthRst;
      fh_q   <= FrameHeightRst;
      kern_q <= KernelRst;
      div_q  <= DivisorRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgFrameWidth:  fw_q   <= cfg_data_i[10:0];
        CfgFrameHeight: fh_q   <= cfg_data_i[11:0];
        CfgKernel:      kern_q <= cfg_data_i[35:0];
        CfgDivisor:     div_q  <= cfg_data_i[6:0];
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      item_q  <= '0;
      col_q   <= '0;
      flush_q <= '0;
      addr_q  <= '0;
      row_q   <= '0;
      win_q   <= '0;
      has2_q  <= 1'b0;
      b_q     <= '0;
      res_q   <= '0;
      out_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      if (emit) begin
        ov_q <= 1'b1;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            item_q <= in_data_i;
            addr_q <= rd_addr;
            if (do_work) begin
              state_q <= S_READ;
            end
          end
        end
        S_READ: begin
          if (item_q.kind == KindFlush) begin
            res_q  <= '{pixel_out: newer_rd, end_of_row: last_f, end_of_frame: last_f};
            has2_q <= 1'b0;
            if (last_f) begin
              row_q   <= '0;
              col_q   <= '0;
              flush_q <= '0;
            end else begin
              flush_q <= flush_q + AW'(1);
            end
            state_q <= S_EMIT1;
          end else begin
            win_q  <= win_n;
            b_q    <= newer_rd;
            has2_q <= has2;
            res_q  <= '{pixel_out: win_n[4], end_of_row: 1'b0, end_of_frame: 1'b0};
            if (last_c) begin
              col_q <= '0;
              if (row_inc >= {1'b0, eff_h}) begin
                row_q   <= eff_h;
                flush_q <= '0;
              end else begin
                row_q <= row_inc[11:0];
              end
            end else begin
              col_q <= col_q + AW'(1);
            end
            priority if (has1 && !border) state_q <= S_CALC;
            else if (has1) state_q <= S_EMIT1;
            else if (has2) state_q <= S_EMIT2;
            else state_q <= S_IDLE;
          end
        end
        S_CALC: begin
          if (arith_done) begin
            res_q   <= '{pixel_out: arith_res, end_of_row: 1'b0, end_of_frame: 1'b0};
            state_q <= S_EMIT1;
          end
        end
        S_EMIT1: begin
          if (slot_free) begin
            out_q   <= res_q;
            state_q <= has2_q ? S_EMIT2 : S_IDLE;
          end
        end
        S_EMIT2: begin
          if (slot_free) begin
            out_q   <= '{pixel_out: b_q, end_of_row: 1'b1, end_of_frame: 1'b0};
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== sv/cgf_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module cgf_assertions (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_stall_o,
  input wire logic                          out_valid_o,
  input wire logic                          out_stall_i,
  input wire cgf_pkg::out_t                 out_data_o,
  input wire logic                          cfg_ready_o
);
  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  `CGF_ASSERT_HOLD(a_out_hold, clk_i, rst_ni, out_valid_o, out_stall_i, out_data_o)
  `CGF_ASSERT(a_eof_eor, clk_i, rst_ni, out_valid_o && out_data_o.end_of_frame |-> out_data_o.end_of_row)
  `CGF_ASSERT(a_no_instant, clk_i, rst_ni, in_acc |=> !$rose(out_valid_o))
  // A new result is only loaded while the input side is busy with its beat.
  `CGF_ASSERT(a_busy_stall, clk_i, rst_ni, $rose(out_valid_o) |-> $past(in_stall_o))
  `CGF_ASSERT(a_cfg_ready, clk_i, rst_ni, cfg_ready_o)
endmodule

bind conv3x3_gray_filter cgf_assertions u_cgf_assertions (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o),
  .cfg_ready_o (cfg_ready_o)
);
`default_nettype wire
